// File: rtl/core/tcs_pkg.sv
// ============================================================================
// tcs_pkg
// Shared types and constants for the thermal cycle sequencer: phase codes,
// shuttle and heater targets, register indexes and the result record.
// ============================================================================
package tcs_pkg;

    localparam int unsigned PHASE_W   = 4;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned SECONDS_W = 12;
    localparam int unsigned ELAPSED_W = 22;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [ELAPSED_W-1:0] MS_PER_SECOND = ELAPSED_W'(1000);

    // Sequencer phases, numbered densely from idle.
    localparam logic [PHASE_W-1:0] PH_IDLE          = 4'd0;
    localparam logic [PHASE_W-1:0] PH_INIT_TO_HOT   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_INIT_ENGAGE   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_INIT_HOLD     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_INIT_RELEASE  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TO_COLD       = 4'd5;
    localparam logic [PHASE_W-1:0] PH_COLD_ENGAGE   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_COLD_HOLD     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_COLD_RELEASE  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_TO_HOT        = 4'd9;
    localparam logic [PHASE_W-1:0] PH_HOT_ENGAGE    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_HOT_HOLD      = 4'd11;
    localparam logic [PHASE_W-1:0] PH_HOT_RELEASE   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_TO_READ       = 4'd13;
    localparam logic [PHASE_W-1:0] PH_TO_HOME       = 4'd14;
    localparam logic [PHASE_W-1:0] PH_UNUSED        = 4'd15;

    // Shuttle positions.
    localparam logic [1:0] SHUTTLE_HOME = 2'd0;
    localparam logic [1:0] SHUTTLE_HOT  = 2'd1;
    localparam logic [1:0] SHUTTLE_READ = 2'd2;
    localparam logic [1:0] SHUTTLE_COLD = 2'd3;

    // Heater positions.
    localparam logic [1:0] HEATER_RELEASED = 2'd0;
    localparam logic [1:0] HEATER_HOT      = 2'd1;
    localparam logic [1:0] HEATER_COLD     = 2'd2;
    localparam logic [1:0] HEATER_INVALID  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_N_CYCLES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HOT_SEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_SEC      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_SEC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_EN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_EN       = 3'd5;

    typedef struct packed {
        logic               shuttle_move;
        logic [1:0]         shuttle_target;
        logic               heater_move;
        logic [1:0]         heater_target;
        logic               blue_read_strobe;
        logic               red_read_strobe;
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] cycle_index;
    } result_t;

endpackage

// File: rtl/core/thermal_cycle_sequencer_top.sv
// ============================================================================
// thermal_cycle_sequencer_top
// Phase sequencer for a shuttle-and-heater thermal cycler. Each input
// transaction advances the sequence by at most one phase and yields exactly
// one result transaction carrying servo command strobes, read strobes, the
// new phase and the cycle count.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ----------------------------
//  s_        in         s_valid / s_ready           req_type, shuttle_idle,
//                                                   heater_idle, ms_tick
//  m_        out        m_valid / m_ready           move strobes and targets,
//                                                   read strobes, phase, cycle
//  cfg_      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// The next-state and result logic is combinational: it sits between the
// sequencer state registers and the output register, so a new transaction is
// accepted every cycle while the output side keeps up.
// A two-entry output stage (output register plus skid register) lets one
// transaction be accepted while a finished result is still waiting; s_ready
// falls only when both entries are full.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
// hold timer and cycle count, zeroes all configuration registers and empties
// the output stage. Configuration writes are always accepted.
// ============================================================================
module thermal_cycle_sequencer_top (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic                             s_shuttle_idle,
    input  logic                             s_heater_idle,
    input  logic                             s_ms_tick,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_shuttle_move,
    output logic [1:0]                       m_shuttle_target,
    output logic                             m_heater_move,
    output logic [1:0]                       m_heater_target,
    output logic                             m_blue_read_strobe,
    output logic                             m_red_read_strobe,
    output logic [tcs_pkg::PHASE_W-1:0]      m_phase,
    output logic [tcs_pkg::COUNT_W-1:0]      m_cycle_index,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tcs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]   n_cycles_reg;
    logic [SECONDS_W-1:0] init_hot_sec_reg;
    logic [SECONDS_W-1:0] hot_sec_reg;
    logic [SECONDS_W-1:0] cold_sec_reg;
    logic                 blue_en_reg;
    logic                 red_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_cycles_reg     <= '0;
            init_hot_sec_reg <= '0;
            hot_sec_reg      <= '0;
            cold_sec_reg     <= '0;
            blue_en_reg      <= 1'b0;
            red_en_reg       <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_N_CYCLES:     n_cycles_reg     <= cfg_data[COUNT_W-1:0];
                CFG_INIT_HOT_SEC: init_hot_sec_reg <= cfg_data[SECONDS_W-1:0];
                CFG_HOT_SEC:      hot_sec_reg      <= cfg_data[SECONDS_W-1:0];
                CFG_COLD_SEC:     cold_sec_reg     <= cfg_data[SECONDS_W-1:0];
                CFG_BLUE_EN:      blue_en_reg      <= cfg_data[0];
                CFG_RED_EN:       red_en_reg       <= cfg_data[0];
                default: ;        // Writes beyond the register list are dropped.
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]   phase_reg,   phase_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]   cycle_reg,   cycle_next;
    result_t              res_next;

    logic                 s_accept;

    // Hold timer: the tick is counted first (saturating), then the count is
    // compared against the hold time of whichever hold phase is active.
    logic [SECONDS_W-1:0] hold_sec;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] hold_limit;
    logic                 hold_done;

    always_comb begin
        case (phase_reg)
            PH_INIT_HOLD: hold_sec = init_hot_sec_reg;
            PH_COLD_HOLD: hold_sec = cold_sec_reg;
            default:      hold_sec = hot_sec_reg;
        endcase
    end

    assign elapsed_inc = (s_ms_tick && (elapsed_reg != ELAPSED_MAX))
                         ? elapsed_reg + ELAPSED_W'(1) : elapsed_reg;
    // 1000 x 4095 fits in the timer width, so the product never wraps.
    assign hold_limit  = ELAPSED_W'(hold_sec) * MS_PER_SECOND;
    assign hold_done   = (elapsed_inc > hold_limit);

    // Next-state and result logic for one input transaction.
    always_comb begin
        phase_next = phase_reg;
        elapsed_next = elapsed_reg;
        cycle_next = cycle_reg;
        res_next = '0;

        if (s_req_type) begin
            // A start request restarts from any phase and ignores the poll inputs.
            phase_next              = PH_INIT_TO_HOT;
            res_next.shuttle_move   = 1'b1;
            res_next.shuttle_target = SHUTTLE_HOT;
        end else begin
            unique case (phase_reg)
                PH_INIT_TO_HOT, PH_TO_HOT: begin
                    if (s_shuttle_idle) begin
                        res_next.heater_move   = 1'b1;
                        res_next.heater_target = HEATER_HOT;
                        phase_next = (phase_reg == PH_TO_HOT) ? PH_HOT_ENGAGE
                                                              : PH_INIT_ENGAGE;
                    end
                end
                PH_INIT_ENGAGE, PH_COLD_ENGAGE, PH_HOT_ENGAGE: begin
                    if (s_heater_idle) begin
                        elapsed_next = '0;
                        phase_next   = phase_reg + PHASE_W'(1);
                    end
                end
                PH_INIT_HOLD, PH_COLD_HOLD, PH_HOT_HOLD: begin
                    elapsed_next = elapsed_inc;
                    if (hold_done) begin
                        res_next.heater_move   = 1'b1;
                        res_next.heater_target = HEATER_RELEASED;
                        phase_next             = phase_reg + PHASE_W'(1);
                    end
                end
                PH_INIT_RELEASE: begin
                    if (s_heater_idle) begin
                        cycle_next              = '0;
                        res_next.shuttle_move   = 1'b1;
                        res_next.shuttle_target = SHUTTLE_COLD;
                        phase_next              = PH_TO_COLD;
                    end
                end
                PH_TO_COLD: begin
                    if (s_shuttle_idle) begin
                        res_next.heater_move   = 1'b1;
                        res_next.heater_target = HEATER_COLD;
                        phase_next             = PH_COLD_ENGAGE;
                    end
                end
                PH_COLD_RELEASE: begin
                    if (s_heater_idle) begin
                        res_next.shuttle_move   = 1'b1;
                        res_next.shuttle_target = SHUTTLE_HOT;
                        phase_next              = PH_TO_HOT;
                    end
                end
                PH_HOT_RELEASE: begin
                    if (s_heater_idle) begin
                        res_next.shuttle_move   = 1'b1;
                        res_next.shuttle_target = SHUTTLE_READ;
                        phase_next              = PH_TO_READ;
                    end
                end
                PH_TO_READ: begin
                    if (s_shuttle_idle) begin
                        res_next.blue_read_strobe = blue_en_reg;
                        res_next.red_read_strobe  = red_en_reg;
                        res_next.shuttle_move     = 1'b1;
                        if (cycle_reg < n_cycles_reg) begin
                            cycle_next              = cycle_reg + COUNT_W'(1);
                            res_next.shuttle_target = SHUTTLE_COLD;
                            phase_next              = PH_TO_COLD;
                        end else begin
                            cycle_next              = '0;
                            res_next.shuttle_target = SHUTTLE_HOME;
                            phase_next              = PH_TO_HOME;
                        end
                    end
                end
                PH_TO_HOME: begin
                    if (s_shuttle_idle) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: ;  // Idle and the unused code do nothing.
            endcase
        end

        res_next.phase       = phase_next;
        res_next.cycle_index = cycle_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            cycle_reg   <= '0;
        end else if (s_accept) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            cycle_reg   <= cycle_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: output register backed by a skid register
    // ------------------------------------------------------------------
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    m_take;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_take   = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_take && skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (s_accept && (m_take || !out_valid_reg)) begin
            out_reg <= res_next;
        end
        if (s_accept && out_valid_reg && !m_take) begin
            skid_reg <= res_next;
        end
    end

    assign m_shuttle_move     = out_reg.shuttle_move;
    assign m_shuttle_target   = out_reg.shuttle_target;
    assign m_heater_move      = out_reg.heater_move;
    assign m_heater_target    = out_reg.heater_target;
    assign m_blue_read_strobe = out_reg.blue_read_strobe;
    assign m_red_read_strobe  = out_reg.red_read_strobe;
    assign m_phase            = out_reg.phase;
    assign m_cycle_index      = out_reg.cycle_index;

endmodule

// File: rtl/core/tcs_checker.sv
// ============================================================================
// tcs_checker
// Port-level checks on the thermal cycle sequencer's result channel.
// ============================================================================
module tcs_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_req_type,
    input logic                             s_shuttle_idle,
    input logic                             s_heater_idle,
    input logic                             s_ms_tick,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_shuttle_move,
    input logic [1:0]                       m_shuttle_target,
    input logic                             m_heater_move,
    input logic [1:0]                       m_heater_target,
    input logic                             m_blue_read_strobe,
    input logic                             m_red_read_strobe,
    input logic [tcs_pkg::PHASE_W-1:0]      m_phase,
    input logic [tcs_pkg::COUNT_W-1:0]      m_cycle_index,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [tcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [tcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tcs_pkg::*;

    // Targets are only meaningful alongside their move strobe.
    a_idle_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_shuttle_move || m_shuttle_target == SHUTTLE_HOME) &&
                     (m_heater_move || m_heater_target == HEATER_RELEASED)))
        else $error("target set without a move strobe");

    // Reads are only strobed as the shuttle leaves the read station.
    a_read_with_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_blue_read_strobe || m_red_read_strobe)) |->
            (m_shuttle_move && m_phase != PH_TO_READ))
        else $error("read strobe without leaving the read station");

    // The unused phase code and heater code never appear.
    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_phase != PH_UNUSED && m_heater_target != HEATER_INVALID))
        else $error("unused phase or heater code in a result");

    // A start request accepted into an empty output stage lands in the first phase with a shuttle move.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type && !m_valid) |=>
            (m_valid && m_phase == PH_INIT_TO_HOT && m_shuttle_move &&
             m_shuttle_target == SHUTTLE_HOT))
        else $error("start request did not restart the sequence");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_phase) &&
                                   $stable(m_cycle_index)))
        else $error("result changed while stalled");

endmodule

bind thermal_cycle_sequencer_top tcs_checker u_tcs_checker (.*);

// File: tb/tcs_sequence_checker.sv
// ============================================================================
// tcs_sequence_checker
// Watches the input, result and register-write channels of the thermal cycle
// sequencer, predicts each result from its own copy of the sequencer state and
// registers, and compares every result transaction field by field.
// ============================================================================
module tcs_sequence_checker (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_req_type,
    input  logic                           s_shuttle_idle,
    input  logic                           s_heater_idle,
    input  logic                           s_ms_tick,

    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_shuttle_move,
    input  logic [1:0]                     m_shuttle_target,
    input  logic                           m_heater_move,
    input  logic [1:0]                     m_heater_target,
    input  logic                           m_blue_read_strobe,
    input  logic                           m_red_read_strobe,
    input  logic [tcs_pkg::PHASE_W-1:0]    m_phase,
    input  logic [tcs_pkg::COUNT_W-1:0]    m_cycle_index,

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data,

    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcs_pkg::*;

    // Sequencer state as predicted.
    logic [PHASE_W-1:0]   phase_q;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [COUNT_W-1:0]   cycle_count;

    // Register copies.
    logic [COUNT_W-1:0]   n_cycles_q;
    logic [SECONDS_W-1:0] init_hot_s;
    logic [SECONDS_W-1:0] hot_s;
    logic [SECONDS_W-1:0] cold_s;
    logic                 blue_en;
    logic                 red_en;

    result_t pending_results[$];
    result_t head;
    int      errors = 0;

    // A tick counts first; the hold ends once the count passes the limit.
    function automatic bit hold_expired(input logic tick, input logic [SECONDS_W-1:0] secs);
        if (tick && elapsed_ms != ELAPSED_MAX)
            elapsed_ms = elapsed_ms + ELAPSED_W'(1);
        return 32'(elapsed_ms) > 32'(secs) * 32'(MS_PER_SECOND);
    endfunction

    function automatic result_t step_sequencer(input logic start, input logic sh_idle,
                                               input logic ht_idle, input logic tick);
        result_t r;
        r = '0;
        if (start) begin
            phase_q          = PH_INIT_TO_HOT;
            r.shuttle_move   = 1'b1;
            r.shuttle_target = SHUTTLE_HOT;
        end else begin
            case (phase_q)
                PH_INIT_TO_HOT, PH_TO_HOT: begin
                    if (sh_idle) begin
                        r.heater_move   = 1'b1;
                        r.heater_target = HEATER_HOT;
                        phase_q = (phase_q == PH_TO_HOT) ? PH_HOT_ENGAGE : PH_INIT_ENGAGE;
                    end
                end
                PH_INIT_ENGAGE, PH_COLD_ENGAGE, PH_HOT_ENGAGE: begin
                    if (ht_idle) begin
                        elapsed_ms = '0;
                        phase_q    = phase_q + PHASE_W'(1);
                    end
                end
                PH_INIT_HOLD: begin
                    if (hold_expired(tick, init_hot_s)) begin
                        r.heater_move = 1'b1;
                        phase_q       = PH_INIT_RELEASE;
                    end
                end
                PH_COLD_HOLD: begin
                    if (hold_expired(tick, cold_s)) begin
                        r.heater_move = 1'b1;
                        phase_q       = PH_COLD_RELEASE;
                    end
                end
                PH_HOT_HOLD: begin
                    if (hold_expired(tick, hot_s)) begin
                        r.heater_move = 1'b1;
                        phase_q       = PH_HOT_RELEASE;
                    end
                end
                PH_INIT_RELEASE: begin
                    if (ht_idle) begin
                        cycle_count      = '0;
                        r.shuttle_move   = 1'b1;
                        r.shuttle_target = SHUTTLE_COLD;
                        phase_q          = PH_TO_COLD;
                    end
                end
                PH_TO_COLD: begin
                    if (sh_idle) begin
                        r.heater_move   = 1'b1;
                        r.heater_target = HEATER_COLD;
                        phase_q         = PH_COLD_ENGAGE;
                    end
                end
                PH_COLD_RELEASE: begin
                    if (ht_idle) begin
                        r.shuttle_move   = 1'b1;
                        r.shuttle_target = SHUTTLE_HOT;
                        phase_q          = PH_TO_HOT;
                    end
                end
                PH_HOT_RELEASE: begin
                    if (ht_idle) begin
                        r.shuttle_move   = 1'b1;
                        r.shuttle_target = SHUTTLE_READ;
                        phase_q          = PH_TO_READ;
                    end
                end
                PH_TO_READ: begin
                    if (sh_idle) begin
                        r.blue_read_strobe = blue_en;
                        r.red_read_strobe  = red_en;
                        r.shuttle_move     = 1'b1;
                        if (cycle_count < n_cycles_q) begin
                            cycle_count      = cycle_count + COUNT_W'(1);
                            r.shuttle_target = SHUTTLE_COLD;
                            phase_q          = PH_TO_COLD;
                        end else begin
                            cycle_count      = '0;
                            r.shuttle_target = SHUTTLE_HOME;
                            phase_q          = PH_TO_HOME;
                        end
                    end
                end
                PH_TO_HOME: begin
                    if (sh_idle)
                        phase_q = PH_IDLE;
                end
                default: begin
                end
            endcase
        end
        r.phase       = phase_q;
        r.cycle_index = cycle_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_q     = PH_IDLE;
            elapsed_ms  = '0;
            cycle_count = '0;
            n_cycles_q  = '0;
            init_hot_s  = '0;
            hot_s       = '0;
            cold_s      = '0;
            blue_en     = 1'b0;
            red_en      = 1'b0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_N_CYCLES:     n_cycles_q = cfg_data[COUNT_W-1:0];
                    CFG_INIT_HOT_SEC: init_hot_s = cfg_data[SECONDS_W-1:0];
                    CFG_HOT_SEC:      hot_s      = cfg_data[SECONDS_W-1:0];
                    CFG_COLD_SEC:     cold_s     = cfg_data[SECONDS_W-1:0];
                    CFG_BLUE_EN:      blue_en    = cfg_data[0];
                    CFG_RED_EN:       red_en     = cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction arrived with no expectation waiting");
                    errors++;
                end else begin
                    head = pending_results.pop_front();
                    check_field("shuttle_move", 32'(head.shuttle_move),
                                32'(m_shuttle_move));
                    check_field("shuttle_target", 32'(head.shuttle_target),
                                32'(m_shuttle_target));
                    check_field("heater_move", 32'(head.heater_move),
                                32'(m_heater_move));
                    check_field("heater_target", 32'(head.heater_target),
                                32'(m_heater_target));
                    check_field("blue_read_strobe", 32'(head.blue_read_strobe),
                                32'(m_blue_read_strobe));
                    check_field("red_read_strobe", 32'(head.red_read_strobe),
                                32'(m_red_read_strobe));
                    check_field("phase", 32'(head.phase), 32'(m_phase));
                    check_field("cycle_index", 32'(head.cycle_index), 32'(m_cycle_index));
                end
            end

            if (s_valid && s_ready)
                pending_results.push_back(step_sequencer(s_req_type, s_shuttle_idle,
                                                         s_heater_idle, s_ms_tick));
        end
        fail_count  <= errors;
        outstanding <= pending_results.size();
    end

endmodule

// File: tb/thermal_cycle_sequencer_top_tb.sv
// ============================================================================
// thermal_cycle_sequencer_top_tb
// Drives the thermal cycle sequencer through directed walks of every phase,
// runs of several cycles with the reads enabled, register changes in the
// middle of a hold and constrained-random polling with random idling on both
// sides. A separate checker predicts and compares every result transaction.
// ============================================================================
module thermal_cycle_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcs_pkg::*;

    // Indexes beyond the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    // Far above what the slowest correct run needs.
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid        = 1'b0;
    logic s_ready;
    logic s_req_type     = 1'b0;
    logic s_shuttle_idle = 1'b0;
    logic s_heater_idle  = 1'b0;
    logic s_ms_tick      = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_shuttle_move;
    logic [1:0]          m_shuttle_target;
    logic                m_heater_move;
    logic [1:0]          m_heater_target;
    logic                m_blue_read_strobe;
    logic                m_red_read_strobe;
    logic [PHASE_W-1:0]  m_phase;
    logic [COUNT_W-1:0]  m_cycle_index;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int outstanding;

    // Idling rates in percent. The sender's rate is only used by the stimulus
    // process; the receiver's is updated with a nonblocking assignment so that
    // the receiver process sees a stable value at every edge.
    int unsigned send_idle_pct = 28;
    int unsigned recv_idle_pct = 28;

    // Set once by the stimulus to request the single long receiver hold-off.
    bit          hold_off_armed = 1'b0;
    bit          hold_off_used  = 1'b0;
    int unsigned hold_off_left  = 0;

    int unsigned cycles = 0;

    always #1 aclk = ~aclk;

    thermal_cycle_sequencer_top DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_shuttle_idle     (s_shuttle_idle),
        .s_heater_idle      (s_heater_idle),
        .s_ms_tick          (s_ms_tick),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_shuttle_move     (m_shuttle_move),
        .m_shuttle_target   (m_shuttle_target),
        .m_heater_move      (m_heater_move),
        .m_heater_target    (m_heater_target),
        .m_blue_read_strobe (m_blue_read_strobe),
        .m_red_read_strobe  (m_red_read_strobe),
        .m_phase            (m_phase),
        .m_cycle_index      (m_cycle_index),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    tcs_sequence_checker sequence_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_shuttle_idle     (s_shuttle_idle),
        .s_heater_idle      (s_heater_idle),
        .s_ms_tick          (s_ms_tick),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_shuttle_move     (m_shuttle_move),
        .m_shuttle_target   (m_shuttle_target),
        .m_heater_move      (m_heater_move),
        .m_heater_target    (m_heater_target),
        .m_blue_read_strobe (m_blue_read_strobe),
        .m_red_read_strobe  (m_red_read_strobe),
        .m_phase            (m_phase),
        .m_cycle_index      (m_cycle_index),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .outstanding        (outstanding)
    );

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result receiver. Normally it drops ready at random; once armed it holds
    // ready low for a long stretch so that the output stage fills and the
    // sequencer has to push back on the input channel.
    always @(posedge aclk) begin
        if (hold_off_armed && !hold_off_used) begin
            hold_off_used = 1'b1;
            hold_off_left = 90;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic set_idling(input int unsigned pct);
        send_idle_pct = pct;
        recv_idle_pct <= pct;
    endtask

    // Offers one input transaction, possibly after some idle cycles, and
    // returns at the edge where it is accepted. Valid is only ever assigned
    // once per edge, so back-to-back transactions keep it high throughout.
    task automatic send_item(input logic start, input logic sh_idle,
                             input logic ht_idle, input logic tick);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= start;
        s_shuttle_idle <= sh_idle;
        s_heater_idle  <= ht_idle;
        s_ms_tick      <= tick;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic poll(input logic sh_idle, input logic ht_idle, input logic tick);
        send_item(1'b0, sh_idle, ht_idle, tick);
    endtask

    // Polls with both servos reported idle and a tick on every transaction,
    // so the sequence moves on as fast as the hold times allow.
    task automatic advance_ideal(input int unsigned count);
        repeat (count) poll(1'b1, 1'b1, 1'b1);
    endtask

    // Stops offering and waits until every expected result has been taken,
    // then lets the clock run on idle before returning.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_registers(input logic [CFG_DATA_W-1:0] n_cycles,
                                     input logic [CFG_DATA_W-1:0] init_hot,
                                     input logic [CFG_DATA_W-1:0] hot,
                                     input logic [CFG_DATA_W-1:0] cold,
                                     input logic [CFG_DATA_W-1:0] blue,
                                     input logic [CFG_DATA_W-1:0] red);
        write_reg(CFG_N_CYCLES, n_cycles);
        write_reg(CFG_INIT_HOT_SEC, init_hot);
        write_reg(CFG_HOT_SEC, hot);
        write_reg(CFG_COLD_SEC, cold);
        write_reg(CFG_BLUE_EN, blue);
        write_reg(CFG_RED_EN, red);
    endtask

    // Mostly well-formed polling: servos usually report idle and ticks are
    // frequent, so complete runs happen. A few start requests restart the
    // sequence mid-run, and some transactions are pure noise.
    task automatic random_items(input int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else if (pick < 10)
                send_item($urandom_range(15) == 0, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                poll($urandom_range(99) < 70, $urandom_range(99) < 70,
                     $urandom_range(99) < 75);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk with every register at its reset value of zero: each
        // initial phase is first held by a missing flag and then released, zero hold
        // times end at the first tick, and start requests arrive from idle, from the
        // move to the read station and from the middle of the sequence.
        poll(1'b1, 1'b1, 1'b1);
        send_item(1'b1, 1'b0, 1'b0, 1'b0);
        poll(1'b0, 1'b1, 1'b1);
        poll(1'b1, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 1'b1);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b1, 1'b1, 1'b0);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b1, 1'b0, 1'b1);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b1, 1'b0, 1'b0);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b1, 1'b1, 1'b1);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b1, 1'b0, 1'b0);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b0, 1'b1, 1'b1);
        send_item(1'b1, 1'b1, 1'b1, 1'b1);
        advance_ideal(2);
        send_item(1'b1, 1'b0, 1'b1, 1'b0);
        advance_ideal(1);
        wait_quiet();

        // A run with both reads enabled, zero hold times and three visits to the read station. This
        // starts a long stretch with no idling on either side, which runs on
        // through the next run.
        program_registers(12'd2, 12'd0, 12'd0, 12'd0, 12'd1, 12'd1);
        set_idling(0);
        send_item(1'b1, 1'b0, 1'b0, 1'b0);
        advance_ideal(36);
        wait_quiet();

        // A longer run with twenty-one reads, walking the index up to twenty.
        program_registers(12'd20, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0);
        send_item(1'b1, 1'b1, 1'b1, 1'b1);
        advance_ideal(200);
        wait_quiet();
        set_idling(28);

        // Hold times at their maximum park the sequence in each hold; the
        // register is then rewritten with the hold still running and the new
        // value has to take effect at the very next compare. Writes to the
        // unmapped indexes and to unused upper data bits change nothing.
        program_registers(12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'hFFF);
        write_reg(CFG_UNMAPPED_LO, 12'hFFF);
        write_reg(CFG_UNMAPPED_HI, 12'hFFF);
        send_item(1'b1, 1'b0, 1'b0, 1'b0);
        advance_ideal(30);
        wait_quiet();
        write_reg(CFG_INIT_HOT_SEC, 12'd0);
        advance_ideal(12);
        wait_quiet();
        write_reg(CFG_COLD_SEC, 12'd0);
        advance_ideal(12);
        wait_quiet();
        write_reg(CFG_HOT_SEC, 12'd0);
        advance_ideal(12);
        wait_quiet();

        // Random polling under three settings. The long receiver hold-off is
        // requested at the start, while the sender keeps offering.
        hold_off_armed <= 1'b1;
        program_registers(12'hF02, 12'd0, 12'd0, 12'd0, 12'hFFE, 12'd1);
        random_items(140);
        wait_quiet();
        program_registers(12'd1, 12'd0, 12'd0, 12'd0, 12'd1, 12'd1);
        random_items(140);
        wait_quiet();
        program_registers(12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0);
        random_items(140);
        wait_quiet();

        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/tcs_pkg.sv
rtl/core/thermal_cycle_sequencer_top.sv
rtl/core/tcs_checker.sv
tb/tcs_sequence_checker.sv
tb/thermal_cycle_sequencer_top_tb.sv
